@@ sv/fifo_scheduler_with_sleep_queue_top_assert.svh @@
// Assertion macros for the scheduler checker
`ifndef FIFO_SCHEDULER_WITH_SLEEP_QUEUE_TOP_ASSERT_SVH
`define FIFO_SCHEDULER_WITH_SLEEP_QUEUE_TOP_ASSERT_SVH
// implication checked every clock outside reset
`define FSQ_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (c)) \
    else $error("fsq check failed");
// next-cycle implication
`define FSQ_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (c)) \
    else $error("fsq check failed");
`endif

@@ sv/fsq_pkg.sv @@
`default_nettype none
package fsq_pkg;
  localparam int unsigned ThreadSlots = 16;
  localparam int unsigned TickBits    = 16;
  localparam int unsigned IdxW        = $clog2(ThreadSlots);
  localparam int unsigned CntW        = $clog2(ThreadSlots + 1);

  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_PREEMPT = 3'd1,
    OP_SLEEP   = 3'd2,
    OP_BLOCK   = 3'd3,
    OP_TICK    = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_NORUN = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_SHIFT,
    S_DEC,
    S_WAKE,
    S_COMPACT,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  thread_id;
    logic [15:0] sleep_ticks;
  } in_t;

  typedef struct packed {
    logic [3:0] running_id;
    logic       running_idle;
    logic [3:0] woken_id;
    logic       woken_valid;
    logic [1:0] status;
    logic       last;
  } out_t;
endpackage
`default_nettype wire

@@ sv/fsq_if.sv @@
`default_nettype none
interface fsq_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [3:0]  thread_id;
  logic [15:0] sleep_ticks;
  modport source (output valid, op, thread_id, sleep_ticks, input ready);
  modport sink (input valid, op, thread_id, sleep_ticks, output ready);
endinterface

interface fsq_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] running_id;
  logic       running_idle;
  logic [3:0] woken_id;
  logic       woken_valid;
  logic [1:0] status;
  logic       last;
  modport source (output valid, running_id, running_idle, woken_id, woken_valid, status,
                  last, input ready);
  modport sink (input valid, running_id, running_idle, woken_id, woken_valid, status,
                last, output ready);
endinterface
`default_nettype wire

@@ sv/fifo_scheduler_with_sleep_queue_top.sv @@
// channel | dir | payload
// in_i    | in  | op, thread_id, sleep_ticks
// out_o   | out | running_id, running_idle, woken_id, woken_valid, status, last
// Ready queue ops go from the input transfer straight to their output transfer.
// Sleep insertion walks up to the slot, then shifts entries down from the list end to it.
// A tick walks the list to decrement, emits one transfer per woken thread,
// then compacts after the last transfer.
// All walks share one entry-step counter. Reset clears counts and the running thread.
// A stalled output holds the sequencer; no input is taken until the item is finished.
`default_nettype none
module fifo_scheduler_with_sleep_queue_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fsq_in_if.sink    in_i,
  fsq_out_if.source out_o
);
  import fsq_pkg::*;

  state_e state_q, state_d;
  logic [3:0]      rq_ids_q [ThreadSlots];
  logic [3:0]      sl_ids_q [ThreadSlots];
  logic [TickBits-1:0] sl_rem_q [ThreadSlots];
  logic [IdxW-1:0] rq_head_q;
  logic [CntW-1:0] rq_cnt_q, sl_cnt_q;
  logic [3:0]      cur_id_q;
  logic            cur_val_q;
  logic [TickBits-1:0] tk_q;
  logic [CntW-1:0] i_q;   // shared walk index
  logic [CntW-1:0] pos_q, woken_q;
  out_t            res_q;

  assign in_i.ready = (state_q == S_IDLE);
  assign out_o.valid = (state_q == S_OUT);
  assign out_o.running_id   = res_q.running_id;
  assign out_o.running_idle = res_q.running_idle;
  assign out_o.woken_id     = res_q.woken_id;
  assign out_o.woken_valid  = res_q.woken_valid;
  assign out_o.status       = res_q.status;
  assign out_o.last         = res_q.last;

  logic [IdxW-1:0] tail_w;
  assign tail_w = rq_head_q + rq_cnt_q[IdxW-1:0];
  logic [IdxW-1:0] i_w;
  assign i_w = i_q[IdxW-1:0];

  // look one entry ahead so the final woken transfer carries last
  logic [CntW-1:0] wk_nxt_w;
  logic            wake_now_w, wake_next_w;
  assign wk_nxt_w    = woken_q + 1'b1;
  assign wake_now_w  = (woken_q < sl_cnt_q) && (sl_rem_q[woken_q[IdxW-1:0]] == '0);
  assign wake_next_w = (wk_nxt_w < sl_cnt_q) && (sl_rem_q[wk_nxt_w[IdxW-1:0]] == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  logic resume_wake_q; // after an output transfer in a tick, continue waking

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_i.valid) begin
        if (in_i.op == OP_SLEEP && in_i.sleep_ticks != '0 && cur_val_q &&
            sl_cnt_q != CntW'(ThreadSlots)) state_d = S_FIND;
        else if (in_i.op == OP_TICK) state_d = S_DEC;
        else state_d = S_OUT;
      end
      S_FIND: if (i_q == sl_cnt_q || sl_rem_q[i_w] > tk_q) state_d = S_SHIFT;
      S_SHIFT: if (i_q == pos_q) state_d = S_OUT;
      S_DEC: if (i_q == sl_cnt_q) state_d = S_WAKE;
      S_WAKE: state_d = S_OUT;
      S_COMPACT: if (i_q == sl_cnt_q) state_d = S_IDLE;
      S_OUT: if (out_o.ready) begin
        if (resume_wake_q) state_d = S_WAKE;
        else if (woken_q != '0) state_d = S_COMPACT;
        else state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_head_q <= '0; rq_cnt_q <= '0; sl_cnt_q <= '0;
      cur_id_q <= '0; cur_val_q <= 1'b0; resume_wake_q <= 1'b0;
      tk_q <= '0; i_q <= '0; pos_q <= '0; woken_q <= '0; res_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: if (in_i.valid) begin
          tk_q <= in_i.sleep_ticks;
          i_q <= '0; woken_q <= '0; resume_wake_q <= 1'b0;
          res_q.woken_id <= '0; res_q.woken_valid <= 1'b0; res_q.last <= 1'b1;
          res_q.status <= ST_OK;
          res_q.running_id <= cur_val_q ? cur_id_q : '0;
          res_q.running_idle <= !cur_val_q;
          case (in_i.op)
            OP_ADD: begin
              if (rq_cnt_q == CntW'(ThreadSlots)) res_q.status <= ST_FULL;
              else begin
                rq_ids_q[tail_w] <= in_i.thread_id;
                rq_cnt_q <= rq_cnt_q + 1'b1;
              end
            end
            OP_PREEMPT, OP_SLEEP, OP_BLOCK: begin
              if (in_i.op != OP_PREEMPT && !cur_val_q) res_q.status <= ST_NORUN;
              else if (in_i.op == OP_SLEEP && in_i.sleep_ticks != '0 &&
                       sl_cnt_q == CntW'(ThreadSlots)) res_q.status <= ST_FULL;
              else if (in_i.op == OP_BLOCK) begin
                if (rq_cnt_q != '0) begin
                  cur_id_q <= rq_ids_q[rq_head_q]; cur_val_q <= 1'b1;
                  rq_head_q <= rq_head_q + 1'b1; rq_cnt_q <= rq_cnt_q - 1'b1;
                  res_q.running_id <= rq_ids_q[rq_head_q]; res_q.running_idle <= 1'b0;
                end else begin
                  cur_id_q <= '0; cur_val_q <= 1'b0;
                  res_q.running_id <= '0; res_q.running_idle <= 1'b1;
                end
              end else if (in_i.op == OP_SLEEP && in_i.sleep_ticks != '0) begin
                // handled by the insertion walk
              end else if (rq_cnt_q != '0) begin
                // preempt or zero-tick sleep: head leaves, old runner joins the tail
                cur_id_q <= rq_ids_q[rq_head_q]; cur_val_q <= 1'b1;
                rq_head_q <= rq_head_q + 1'b1;
                res_q.running_id <= rq_ids_q[rq_head_q]; res_q.running_idle <= 1'b0;
                if (cur_val_q) rq_ids_q[tail_w] <= cur_id_q;
                else rq_cnt_q <= rq_cnt_q - 1'b1;
              end
            end
            default: ;
          endcase
        end
        S_FIND: begin
          if (i_q == sl_cnt_q || sl_rem_q[i_w] > tk_q) begin
            pos_q <= i_q; i_q <= sl_cnt_q;
          end else i_q <= i_q + 1'b1;
        end
        S_SHIFT: begin
          if (i_q == pos_q) begin
            sl_ids_q[i_w] <= cur_id_q; sl_rem_q[i_w] <= tk_q;
            sl_cnt_q <= sl_cnt_q + 1'b1;
            if (rq_cnt_q != '0) begin
              cur_id_q <= rq_ids_q[rq_head_q]; cur_val_q <= 1'b1;
              rq_head_q <= rq_head_q + 1'b1; rq_cnt_q <= rq_cnt_q - 1'b1;
              res_q.running_id <= rq_ids_q[rq_head_q]; res_q.running_idle <= 1'b0;
            end else begin
              cur_id_q <= '0; cur_val_q <= 1'b0;
              res_q.running_id <= '0; res_q.running_idle <= 1'b1;
            end
          end else begin
            sl_ids_q[i_w] <= sl_ids_q[i_w - 1'b1];
            sl_rem_q[i_w] <= sl_rem_q[i_w - 1'b1];
            i_q <= i_q - 1'b1;
          end
        end
        S_DEC: begin
          if (i_q == sl_cnt_q) i_q <= '0;
          else begin
            if (sl_rem_q[i_w] != '0) sl_rem_q[i_w] <= sl_rem_q[i_w] - 1'b1;
            i_q <= i_q + 1'b1;
          end
        end
        S_WAKE: begin
          if (wake_now_w) begin
            res_q.woken_id <= sl_ids_q[woken_q[IdxW-1:0]];
            res_q.woken_valid <= 1'b1;
            if (rq_cnt_q == CntW'(ThreadSlots)) res_q.status <= ST_FULL;
            else begin
              res_q.status <= ST_OK;
              rq_ids_q[tail_w] <= sl_ids_q[woken_q[IdxW-1:0]];
              rq_cnt_q <= rq_cnt_q + 1'b1;
            end
            woken_q <= wk_nxt_w;
            i_q <= wk_nxt_w;
            resume_wake_q <= wake_next_w;
            res_q.last <= !wake_next_w;
          end else resume_wake_q <= 1'b0;
        end
        S_COMPACT: begin
          if (i_q == sl_cnt_q) begin
            sl_cnt_q <= sl_cnt_q - woken_q;
          end else begin
            sl_ids_q[i_w - woken_q[IdxW-1:0]] <= sl_ids_q[i_w];
            sl_rem_q[i_w - woken_q[IdxW-1:0]] <= sl_rem_q[i_w];
            i_q <= i_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ sv/fsq_checker.sv @@
`default_nettype none
`include "fifo_scheduler_with_sleep_queue_top_assert.svh"
module fsq_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid, in_ready, out_valid, out_ready,
  input wire logic running_idle, woken_valid, last,
  input wire logic [3:0] running_id, woken_id
);
  `FSQ_ASSERT_IMP(a_excl, in_ready, !out_valid)
  `FSQ_ASSERT_IMP(a_idle_id, out_valid && running_idle, running_id == 4'd0)
  `FSQ_ASSERT_IMP(a_wid, out_valid && !woken_valid, woken_id == 4'd0)
  `FSQ_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(last))
  `FSQ_ASSERT_NXT(a_busy, in_valid && in_ready, !in_ready)
endmodule

bind fifo_scheduler_with_sleep_queue_top fsq_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_i.valid), .in_ready(in_i.ready),
  .out_valid(out_o.valid), .out_ready(out_o.ready),
  .running_idle(out_o.running_idle), .woken_valid(out_o.woken_valid),
  .last(out_o.last), .running_id(out_o.running_id), .woken_id(out_o.woken_id)
);
`default_nettype wire

@@ dv/tb_fifo_scheduler_with_sleep_queue_top.sv @@
`timescale 1ns / 1ps
module tb_fifo_scheduler_with_sleep_queue_top;
  import fsq_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  fsq_in_if  in_if ();
  fsq_out_if out_if ();

  fifo_scheduler_with_sleep_queue_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  thread_id;
    logic [15:0] sleep_ticks;
  } req_t;

  typedef struct packed {
    logic [3:0] running_id;
    logic       running_idle;
    logic [3:0] woken_id;
    logic       woken_valid;
    logic [1:0] status;
    logic       last;
  } sched_res_t;

  req_t       pending_q[$];
  sched_res_t sched_exp_q[$];

  // predictor state
  logic [3:0]  rq_ids[16];
  logic [3:0]  rq_head;
  int unsigned rq_count;
  logic [3:0]  sl_ids[16];
  logic [15:0] sl_left[16];
  int unsigned sl_count;
  logic [3:0]  cur_id;
  logic        cur_valid;

  int  err_count = 0;
  bit  stim_done = 1'b0;
  int  cycle_count = 0;
  int  hold_cycles = 0;

  function automatic bit rq_push(input logic [3:0] id);
    if (rq_count >= 16) return 1'b0;
    rq_ids[4'(rq_head + rq_count)] = id;
    rq_count++;
    return 1'b1;
  endfunction

  function automatic bit rq_pop(output logic [3:0] id);
    id = '0;
    if (rq_count == 0) return 1'b0;
    id = rq_ids[rq_head];
    rq_head = rq_head + 4'd1;
    rq_count--;
    return 1'b1;
  endfunction

  function automatic void push_result(input logic [3:0] wid, input logic wv,
                                      input status_e st);
    sched_res_t r;
    r.running_id   = cur_valid ? cur_id : 4'd0;
    r.running_idle = !cur_valid;
    r.woken_id     = wv ? wid : 4'd0;
    r.woken_valid  = wv;
    r.status       = st;
    r.last         = 1'b0;
    sched_exp_q.push_back(r);
  endfunction

  function automatic void predict_schedule(input req_t rq);
    logic [3:0] id;
    status_e    st;
    int         woken;
    int         pos;
    sched_res_t tail_r;
    st = ST_OK;
    woken = 0;
    case (rq.op)
      OP_ADD: if (!rq_push(rq.thread_id)) st = ST_FULL;
      OP_PREEMPT, OP_SLEEP, OP_BLOCK: begin
        if (rq.op != OP_PREEMPT && !cur_valid) begin
          st = ST_NORUN;
        end else if (rq.op == OP_PREEMPT || (rq.op == OP_SLEEP && rq.sleep_ticks == 0)) begin
          if (rq_pop(id)) begin
            if (cur_valid) void'(rq_push(cur_id));
            cur_id = id;
            cur_valid = 1'b1;
          end
        end else begin
          if (rq.op == OP_SLEEP) begin
            if (sl_count >= 16) begin
              st = ST_FULL;
            end else begin
              pos = 0;
              while (pos < sl_count && sl_left[pos] <= rq.sleep_ticks) pos++;
              for (int i = sl_count; i > pos; i--) begin
                sl_ids[i] = sl_ids[i-1];
                sl_left[i] = sl_left[i-1];
              end
              sl_ids[pos] = cur_id;
              sl_left[pos] = rq.sleep_ticks;
              sl_count++;
            end
          end
          if (st == ST_OK) begin
            cur_valid = rq_pop(id);
            cur_id = id;
          end
        end
      end
      OP_TICK: begin
        for (int i = 0; i < sl_count; i++) if (sl_left[i] != 0) sl_left[i]--;
        while (woken < sl_count && woken < 16 && sl_left[woken] == 0) begin
          id = sl_ids[woken];
          push_result(id, 1'b1, rq_push(id) ? ST_OK : ST_FULL);
          woken++;
        end
        for (int i = woken; i < sl_count; i++) begin
          sl_ids[i-woken] = sl_ids[i];
          sl_left[i-woken] = sl_left[i];
        end
        sl_count -= woken;
      end
      default: ;
    endcase
    if (woken == 0) push_result(4'd0, 1'b0, st);
    tail_r = sched_exp_q.pop_back();
    tail_r.last = 1'b1;
    sched_exp_q.push_back(tail_r);
  endfunction

  // driver
  int in_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.op <= '0;
      in_if.thread_id <= '0;
      in_if.sleep_ticks <= '0;
      in_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_schedule(pending_q.pop_front());
        in_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 11) : 0;
      end
      if (!(in_if.valid && !in_if.ready)) begin
        if (in_gap > 0 || pending_q.size() == 0) begin
          in_if.valid <= 1'b0;
          if (in_gap > 0) in_gap = in_gap - 1;
        end else begin
          in_if.valid <= 1'b1;
          in_if.op <= pending_q[0].op;
          in_if.thread_id <= pending_q[0].thread_id;
          in_if.sleep_ticks <= pending_q[0].sleep_ticks;
        end
      end
    end
  end

  // monitor and receiver stalls
  int out_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    sched_res_t got;
    sched_res_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      out_gap = 0;
    end else begin
      cycle_count <= cycle_count + 1;
      if (out_if.valid && out_if.ready) begin
        got = {out_if.running_id, out_if.running_idle, out_if.woken_id,
               out_if.woken_valid, out_if.status, out_if.last};
        if (sched_exp_q.size() == 0) begin
          $display("%0t: unexpected transfer %h", $realtime, got);
          err_count++;
        end else begin
          want = sched_exp_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %h actual %h", $realtime, want, got);
            err_count++;
          end
        end
        out_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 11) : 0;
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_if.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap = out_gap - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  function automatic req_t mk(input op_e op, input logic [3:0] tid, input logic [15:0] tk);
    req_t r;
    r.op = op;
    r.thread_id = tid;
    r.sleep_ticks = tk;
    return r;
  endfunction

  initial begin
    req_t r;
    int   pick;
    rq_head = '0; rq_count = 0; sl_count = 0; cur_id = '0; cur_valid = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: idle cases, full queue, sleep extremes, ties, unknown ops
    pending_q.push_back(mk(OP_SLEEP, 4'd0, 16'd5));
    pending_q.push_back(mk(OP_BLOCK, 4'd0, 16'd0));
    pending_q.push_back(mk(OP_TICK, 4'd0, 16'd0));
    pending_q.push_back(mk(OP_PREEMPT, 4'd0, 16'd0));
    for (int i = 0; i < 17; i++) pending_q.push_back(mk(OP_ADD, 4'(i), 16'd0));
    pending_q.push_back(mk(OP_PREEMPT, 4'd0, 16'd0));
    pending_q.push_back(mk(OP_SLEEP, 4'd0, 16'hFFFF));
    pending_q.push_back(mk(OP_SLEEP, 4'd0, 16'd1));
    pending_q.push_back(mk(OP_SLEEP, 4'd0, 16'd1));
    pending_q.push_back(mk(OP_SLEEP, 4'd0, 16'd0));
    pending_q.push_back(mk(OP_TICK, 4'd0, 16'd0));
    pending_q.push_back(mk(op_e'(3'd5), 4'hF, 16'hFFFF));
    pending_q.push_back(mk(op_e'(3'd7), 4'h0, 16'h0));

    // random: mostly short sleeps so ticks wake threads
    for (int n = 0; n < 285; n++) begin
      pick = $urandom_range(0, 99);
      r.thread_id = 4'($urandom);
      r.sleep_ticks = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
      if (pick < 22) r.op = OP_ADD;
      else if (pick < 34) r.op = OP_PREEMPT;
      else if (pick < 58) r.op = OP_SLEEP;
      else if (pick < 66) r.op = OP_BLOCK;
      else if (pick < 97) r.op = OP_TICK;
      else r.op = 3'($urandom_range(5, 7));
      pending_q.push_back(r);
      // at one point, fill the sleep list with simultaneous expiries
      if (n == 150) begin
        for (int k = 0; k < 18; k++) begin
          pending_q.push_back(mk(OP_ADD, 4'(k), 16'd0));
          pending_q.push_back(mk(OP_PREEMPT, 4'd0, 16'd0));
          pending_q.push_back(mk(OP_SLEEP, 4'd0, 16'd2));
        end
        pending_q.push_back(mk(OP_TICK, 4'd0, 16'd0));
        pending_q.push_back(mk(OP_TICK, 4'd0, 16'd0));
      end
      if (n == 80) hold_cycles = 400;
    end

    while ((pending_q.size() != 0 || sched_exp_q.size() != 0) && cycle_count < 400000)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (cycle_count >= 400000) begin
      $display("FAILURE");
    end else if (err_count == 0 && sched_exp_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
